FILE: src/assert_macros.svh
// Assertion helpers for the RTL, included by min_priority_queue_core.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define MPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mpq_pkg.sv
package mpq_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int KEY_BITS_DEF  = 32;
    localparam int PRIO_BITS_DEF = 16;

    typedef enum logic [1:0] {
        MODE_ENQ = 2'd0,
        MODE_DEQ = 2'd1,
        MODE_CHG = 2'd2,
        MODE_CLR = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_NO_MATCH = 2'd2,
        STAT_FULL     = 2'd3
    } t_status;

    // Per-cell commands for one execute cycle.
    typedef struct packed {
        logic load;
        logic shift;
        logic chg;
    } t_cell_ctl;

endpackage

FILE: src/mpq_in_if.sv
interface mpq_in_if #(
    parameter int KEY_BITS  = mpq_pkg::KEY_BITS_DEF,
    parameter int PRIO_BITS = mpq_pkg::PRIO_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    mpq_pkg::t_mode              mode;
    logic [KEY_BITS-1:0]         key_value;
    logic signed [PRIO_BITS-1:0] prio_in;

    modport source (output valid, output mode, output key_value, output prio_in,
                    input ready);
    modport sink   (input valid, input mode, input key_value, input prio_in,
                    output ready);
endinterface

FILE: src/mpq_out_if.sv
interface mpq_out_if #(
    parameter int KEY_BITS  = mpq_pkg::KEY_BITS_DEF,
    parameter int PRIO_BITS = mpq_pkg::PRIO_BITS_DEF,
    parameter int CNT_BITS  = $clog2(mpq_pkg::CAPACITY_DEF + 1)
);
    logic                        valid;
    logic                        ready;
    logic [KEY_BITS-1:0]         removed_value;
    mpq_pkg::t_status            status;
    logic [KEY_BITS-1:0]         head_value;
    logic signed [PRIO_BITS-1:0] head_prio;
    logic [CNT_BITS-1:0]         entry_count;
    logic                        is_empty;

    modport source (output valid, output removed_value, output status,
                    output head_value, output head_prio, output entry_count,
                    output is_empty, input ready);
    modport sink   (input valid, input removed_value, input status,
                    input head_value, input head_prio, input entry_count,
                    input is_empty, output ready);
endinterface

FILE: src/mpq_cell.sv
module mpq_cell #(
    parameter int KEY_BITS  = mpq_pkg::KEY_BITS_DEF,
    parameter int PRIO_BITS = mpq_pkg::PRIO_BITS_DEF
) (
    input  logic                   i_clk,
    input  mpq_pkg::t_cell_ctl     i_ctl,
    input  logic [KEY_BITS-1:0]    i_key,
    input  logic [PRIO_BITS-1:0]   i_prio,
    input  logic [KEY_BITS-1:0]    i_next_value,
    input  logic [PRIO_BITS-1:0]   i_next_prio,
    input  logic                   i_found,
    output logic [KEY_BITS-1:0]    o_value,
    output logic [PRIO_BITS-1:0]   o_prio,
    output logic                   o_found
);
    import mpq_pkg::*;

    logic [KEY_BITS-1:0]  r_value, n_value;
    logic [PRIO_BITS-1:0] r_prio, n_prio;
    logic                 w_hit;

    // Qualifies when the value matches and the new priority is strictly lower.
    assign w_hit   = i_ctl.chg && (r_value == i_key) && ($signed(r_prio) > $signed(i_prio));
    assign o_found = i_found || w_hit;

    always_comb begin
        n_value = r_value;
        n_prio  = r_prio;
        if (i_ctl.load) begin
            n_value = i_key;
            n_prio  = i_prio;
        end else if (i_ctl.shift) begin
            // close the gap left by the removed entry
            n_value = i_next_value;
            n_prio  = i_next_prio;
        end else if (w_hit && !i_found) begin
            n_prio = i_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
    end

    assign o_value = r_value;
    assign o_prio  = r_prio;

endmodule

FILE: src/mpq_min_tree.sv
module mpq_min_tree #(
    parameter int CAPACITY  = mpq_pkg::CAPACITY_DEF,
    parameter int KEY_BITS  = mpq_pkg::KEY_BITS_DEF,
    parameter int PRIO_BITS = mpq_pkg::PRIO_BITS_DEF,
    localparam int IDX_BITS = $clog2(CAPACITY)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [CAPACITY-1:0]    i_occupied,
    input  logic [KEY_BITS-1:0]    i_value [CAPACITY],
    input  logic [PRIO_BITS-1:0]   i_prio  [CAPACITY],
    output logic                   o_done,
    output logic                   o_valid,
    output logic [KEY_BITS-1:0]    o_value,
    output logic [PRIO_BITS-1:0]   o_prio,
    output logic [IDX_BITS-1:0]    o_idx
);
    import mpq_pkg::*;

    localparam int LEVELS    = IDX_BITS;
    localparam int PAD       = 1 << IDX_BITS;
    localparam int STEP_BITS = $clog2(LEVELS + 1);

    typedef struct packed {
        logic                 valid;
        logic [KEY_BITS-1:0]  value;
        logic [PRIO_BITS-1:0] prio;
        logic [IDX_BITS-1:0]  idx;
    } t_node;

    // Keep the left node unless the right one is strictly smaller.
    function automatic t_node pick(t_node a, t_node b);
        logic b_less;
        b_less = b.valid && (!a.valid || ($signed(b.prio) < $signed(a.prio)) ||
                 ((b.prio == a.prio) && (b.value < a.value)));
        return b_less ? b : a;
    endfunction

    t_node                r_node [PAD];
    t_node                n_node [PAD];
    t_node                w_leaf [PAD];
    t_node                w_src  [PAD];
    logic                 r_busy;
    logic [STEP_BITS-1:0] r_left;

    always_comb begin
        for (int j = 0; j < PAD; j++) begin
            if (j < CAPACITY) begin
                w_leaf[j].valid = i_occupied[j];
                w_leaf[j].value = i_value[j];
                w_leaf[j].prio  = i_prio[j];
            end else begin
                w_leaf[j].valid = 1'b0;
                w_leaf[j].value = '0;
                w_leaf[j].prio  = '0;
            end
            w_leaf[j].idx = IDX_BITS'(j);
        end
    end

    // One tree level per cycle, folded onto the same node row.
    always_comb begin
        for (int j = 0; j < PAD; j++) begin
            w_src[j] = i_start ? w_leaf[j] : r_node[j];
        end
        for (int j = 0; j < PAD; j++) begin
            if (j < PAD / 2) begin
                n_node[j] = pick(w_src[2 * j], w_src[2 * j + 1]);
            end else begin
                n_node[j] = r_node[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start || (r_busy && (r_left != '0))) begin
            r_node <= n_node;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_left <= STEP_BITS'(LEVELS - 1);
        end else if (r_busy) begin
            if (r_left == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_left <= r_left - STEP_BITS'(1);
            end
        end
    end

    assign o_done  = r_busy && (r_left == '0);
    assign o_valid = r_node[0].valid;
    assign o_value = r_node[0].value;
    assign o_prio  = r_node[0].prio;
    assign o_idx   = r_node[0].idx;

endmodule

FILE: src/min_priority_queue_core.sv
// Flow: an accepted word executes on the cell row (EXEC), then the minimum-reduction tree
//   walks its levels, one level per cycle (START, REDUCE); CAPACITY rounds up to a power of
//   two. The reply is then registered for output, waiting in HOLD while the output stalls.
// A new word is accepted only in IDLE, after the previous reply has been loaded for output.
// Reset (synchronous, active low) empties the queue and clears control state;
//   entry contents stay undefined until written.
module min_priority_queue_core #(
    parameter int CAPACITY   = mpq_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = mpq_pkg::KEY_BITS_DEF,
    parameter int PRIO_BITS  = mpq_pkg::PRIO_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mpq_in_if.sink      i_in,
    mpq_out_if.source   o_out
);
    import mpq_pkg::*;
    `include "assert_macros.svh"

    localparam int IDX_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EXEC   = 5'b00010,
        ST_START  = 5'b00100,
        ST_REDUCE = 5'b01000,
        ST_HOLD   = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    t_mode                r_mode;
    logic [KEY_BITS-1:0]  r_key;
    logic [PRIO_BITS-1:0] r_prio;
    logic [CNT_BITS-1:0]  r_count, n_count;
    t_status              r_status, n_status;
    logic [KEY_BITS-1:0]  r_removed, n_removed;

    logic                 r_head_valid;
    logic [KEY_BITS-1:0]  r_head_value;
    logic [PRIO_BITS-1:0] r_head_prio;
    logic [IDX_BITS-1:0]  r_head_idx;

    logic                 r_out_valid;
    logic [KEY_BITS-1:0]  r_out_removed;
    t_status              r_out_status;
    logic [KEY_BITS-1:0]  r_out_head_value;
    logic [PRIO_BITS-1:0] r_out_head_prio;
    logic [CNT_BITS-1:0]  r_out_count;
    logic                 r_out_empty;

    logic                 w_accept, w_full, w_empty, w_exec, w_slot_free, w_out_load;
    t_cell_ctl            w_ctl       [CAPACITY];
    logic [CAPACITY-1:0]  w_occupied;
    logic [CAPACITY-1:0]  w_load_vec;
    logic [KEY_BITS-1:0]  w_cell_value[CAPACITY];
    logic [PRIO_BITS-1:0] w_cell_prio [CAPACITY];
    logic [CAPACITY:0]    w_found;

    logic                 w_tree_done, w_tree_valid;
    logic [KEY_BITS-1:0]  w_tree_value;
    logic [PRIO_BITS-1:0] w_tree_prio;
    logic [IDX_BITS-1:0]  w_tree_idx;

    logic                 w_hd_valid;
    logic [KEY_BITS-1:0]  w_hd_value;
    logic [PRIO_BITS-1:0] w_hd_prio;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_full      = (r_count == CNT_BITS'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_exec      = (r_state == ST_EXEC);
    assign w_slot_free = !r_out_valid || o_out.ready;

    // ---- cell row ----
    assign w_found[0] = 1'b0;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic [KEY_BITS-1:0]  w_nv;
        logic [PRIO_BITS-1:0] w_np;

        assign w_occupied[gi] = (CNT_BITS'(gi) < r_count);
        assign w_ctl[gi].load  = w_exec && (r_mode == MODE_ENQ) && !w_full &&
                                 (CNT_BITS'(gi) == r_count);
        assign w_ctl[gi].shift = w_exec && (r_mode == MODE_DEQ) && !w_empty &&
                                 (IDX_BITS'(gi) >= r_head_idx);
        assign w_ctl[gi].chg   = w_exec && (r_mode == MODE_CHG) && w_occupied[gi];
        assign w_load_vec[gi]  = w_ctl[gi].load;

        if (gi == CAPACITY - 1) begin : g_last
            assign w_nv = '0;
            assign w_np = '0;
        end else begin : g_mid
            assign w_nv = w_cell_value[gi + 1];
            assign w_np = w_cell_prio[gi + 1];
        end

        mpq_cell #(
            .KEY_BITS  (KEY_BITS),
            .PRIO_BITS (PRIO_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl[gi]),
            .i_key        (r_key),
            .i_prio       (r_prio),
            .i_next_value (w_nv),
            .i_next_prio  (w_np),
            .i_found      (w_found[gi]),
            .o_value      (w_cell_value[gi]),
            .o_prio       (w_cell_prio[gi]),
            .o_found      (w_found[gi + 1])
        );
    end

    // ---- minimum search ----
    mpq_min_tree #(
        .CAPACITY  (CAPACITY),
        .KEY_BITS  (KEY_BITS),
        .PRIO_BITS (PRIO_BITS)
    ) u_tree (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_START),
        .i_occupied (w_occupied),
        .i_value    (w_cell_value),
        .i_prio     (w_cell_prio),
        .o_done     (w_tree_done),
        .o_valid    (w_tree_valid),
        .o_value    (w_tree_value),
        .o_prio     (w_tree_prio),
        .o_idx      (w_tree_idx)
    );

    // ---- operation outcome ----
    always_comb begin
        n_count   = r_count;
        n_status  = STAT_OK;
        n_removed = '0;
        unique case (r_mode)
            MODE_ENQ: begin
                if (w_full) begin
                    n_status = STAT_FULL;
                end else begin
                    n_count = r_count + CNT_BITS'(1);
                end
            end
            MODE_DEQ: begin
                if (w_empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_removed = r_head_value;
                    n_count   = r_count - CNT_BITS'(1);
                end
            end
            MODE_CHG: begin
                if (!w_found[CAPACITY]) begin
                    n_status = STAT_NO_MATCH;
                end
            end
            MODE_CLR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // ---- control ----
    assign w_out_load = ((r_state == ST_REDUCE) && w_tree_done && w_slot_free) ||
                        ((r_state == ST_HOLD) && w_slot_free);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_accept) n_state = ST_EXEC;
            ST_EXEC:   n_state = ST_START;
            ST_START:  n_state = ST_REDUCE;
            ST_REDUCE: begin
                if (w_tree_done) begin
                    n_state = w_slot_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD:   if (w_slot_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_exec) begin
                r_count <= n_count;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---- payload registers ----
    assign w_hd_valid = (r_state == ST_HOLD) ? r_head_valid : w_tree_valid;
    assign w_hd_value = (r_state == ST_HOLD) ? r_head_value : w_tree_value;
    assign w_hd_prio  = (r_state == ST_HOLD) ? r_head_prio  : w_tree_prio;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_in.mode;
            r_key  <= i_in.key_value;
            r_prio <= i_in.prio_in;
        end
        if (w_exec) begin
            r_status  <= n_status;
            r_removed <= n_removed;
        end
        if ((r_state == ST_REDUCE) && w_tree_done) begin
            r_head_valid <= w_tree_valid;
            r_head_value <= w_tree_value;
            r_head_prio  <= w_tree_prio;
            r_head_idx   <= w_tree_idx;
        end
        if (w_out_load) begin
            r_out_removed    <= r_removed;
            r_out_status     <= r_status;
            r_out_head_value <= w_hd_valid ? w_hd_value : '0;
            r_out_head_prio  <= w_hd_valid ? w_hd_prio  : '0;
            r_out_count      <= r_count;
            r_out_empty      <= w_empty;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.removed_value = r_out_removed;
    assign o_out.status        = r_out_status;
    assign o_out.head_value    = r_out_head_value;
    assign o_out.head_prio     = r_out_head_prio;
    assign o_out.entry_count   = r_out_count;
    assign o_out.is_empty      = r_out_empty;

    // ---- checks ----
    `MPQ_ASSERT_NOW(a_done_in_reduce, i_clk, i_rst_n, w_tree_done, (r_state == ST_REDUCE), "tree finished outside reduce")
    `MPQ_ASSERT_NOW(a_single_load, i_clk, i_rst_n, 1'b1, $onehot0(w_load_vec), "more than one cell loaded")
    `MPQ_ASSERT_NEXT(a_enq_grows, i_clk, i_rst_n, (w_exec && (r_mode == MODE_ENQ) && !w_full), (r_count == $past(r_count) + CNT_BITS'(1)), "enqueue did not grow count")
    `MPQ_ASSERT_NOW(a_head_matches_count, i_clk, i_rst_n, ((r_state == ST_REDUCE) && w_tree_done), (w_tree_valid == !w_empty), "minimum validity disagrees with count")

endmodule

FILE: dv/mpq_tb_pkg.sv
package mpq_tb_pkg;

    import mpq_pkg::*;

    localparam int DEPTH = CAPACITY_DEF;
    localparam int KB    = KEY_BITS_DEF;
    localparam int PB    = PRIO_BITS_DEF;
    localparam int CB    = $clog2(CAPACITY_DEF + 1);

    typedef struct {
        logic [KB-1:0]        removed_value;
        t_status              status;
        logic [KB-1:0]        head_value;
        logic signed [PB-1:0] head_prio;
        logic [CB-1:0]        entry_count;
        logic                 is_empty;
    } t_reply;

    // Shadow copy of the queue contents plus the replies still owed by the block.
    class pq_shadow;
        logic [KB-1:0]        cell_value[DEPTH];
        logic signed [PB-1:0] cell_prio[DEPTH];
        int unsigned          held;
        t_reply               owed_replies[$];
        int unsigned          errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        // Lower priority wins, then lower value; the earlier cell keeps a full tie.
        function int least_index();
            int best;
            best = 0;
            for (int i = 1; i < held; i++) begin
                if (cell_prio[i] < cell_prio[best] ||
                    (cell_prio[i] == cell_prio[best] && cell_value[i] < cell_value[best]))
                    best = i;
            end
            return best;
        endfunction

        function void note_op(t_mode mode, logic [KB-1:0] key, logic signed [PB-1:0] prio);
            t_reply r;
            int     m;
            bit     found;
            r.removed_value = '0;
            r.status        = STAT_OK;
            found           = 1'b0;
            case (mode)
                MODE_ENQ: begin
                    if (held >= DEPTH) begin
                        r.status = STAT_FULL;
                    end else begin
                        cell_value[held] = key;
                        cell_prio[held]  = prio;
                        held++;
                    end
                end
                MODE_DEQ: begin
                    if (held == 0) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        m = least_index();
                        r.removed_value = cell_value[m];
                        // close the gap, keeping insertion order
                        for (int i = m + 1; i < held; i++) begin
                            cell_value[i-1] = cell_value[i];
                            cell_prio[i-1]  = cell_prio[i];
                        end
                        held--;
                    end
                end
                MODE_CHG: begin
                    for (int i = 0; i < held; i++) begin
                        if (!found && cell_value[i] == key && cell_prio[i] > prio) begin
                            cell_prio[i] = prio;
                            found = 1'b1;
                        end
                    end
                    r.status = found ? STAT_OK : STAT_NO_MATCH;
                end
                default: begin
                    held = 0;
                end
            endcase
            if (held == 0) begin
                r.head_value = '0;
                r.head_prio  = '0;
                r.is_empty   = 1'b1;
            end else begin
                m = least_index();
                r.head_value = cell_value[m];
                r.head_prio  = cell_prio[m];
                r.is_empty   = 1'b0;
            end
            r.entry_count = CB'(held);
            owed_replies.push_back(r);
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_reply(t_reply got);
            t_reply want;
            if (owed_replies.size() == 0) begin
                $error("reply word with nothing outstanding: head_value %0h, count %0d",
                       got.head_value, got.entry_count);
                errors++;
                return;
            end
            want = owed_replies.pop_front();
            check_field("removed_value", want.removed_value, got.removed_value);
            check_field("status", 64'(want.status), 64'(got.status));
            check_field("head_value", want.head_value, got.head_value);
            check_field("head_prio", 64'(unsigned'(want.head_prio)),
                        64'(unsigned'(got.head_prio)));
            check_field("entry_count", want.entry_count, got.entry_count);
            check_field("is_empty", want.is_empty, got.is_empty);
        endfunction

        function int unsigned outstanding();
            return owed_replies.size();
        endfunction
    endclass

endpackage

FILE: dv/tb_min_priority_queue_core.sv
module tb_min_priority_queue_core;

    timeunit 1ns;
    timeprecision 1ps;

    import mpq_pkg::*;
    import mpq_tb_pkg::*;

    localparam int RANDOM_WORDS = 850;
    localparam int CALM_TAIL    = 150;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_BURST   = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int SEGMENT      = 30;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {LEAN_FILL, LEAN_DRAIN, LEAN_MIX} t_lean;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mpq_in_if  in_if ();
    mpq_out_if out_if ();

    min_priority_queue_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #10 i_clk = ~i_clk;

    pq_shadow tracker = new();

    bit sender_calm = 1'b0;
    bit sink_calm   = 1'b0;
    bit hold_req    = 1'b0;
    bit gaps_on     = 1'b1;

    logic [KB-1:0] key_pool[8];

    // Check each reply word on the falling edge; it is taken at the next rising edge.
    always @(negedge i_clk) begin : reply_mon
        t_reply got;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got.removed_value = out_if.removed_value;
            got.status        = out_if.status;
            got.head_value    = out_if.head_value;
            got.head_prio     = out_if.head_prio;
            got.entry_count   = out_if.entry_count;
            got.is_empty      = out_if.is_empty;
            tracker.check_reply(got);
        end
    end

    initial begin : sink_side
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                // long stall so the block backs up into its input
                hold_req = 1'b0;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!sink_calm && $urandom_range(0, 2) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    // Call at a rising edge; returns at the rising edge that takes the word.
    task automatic send_word(t_mode mode, logic [KB-1:0] key, logic signed [PB-1:0] prio);
        in_if.valid     <= 1'b1;
        in_if.mode      <= mode;
        in_if.key_value <= key;
        in_if.prio_in   <= prio;
        @(negedge i_clk);
        while (in_if.ready !== 1'b1) @(negedge i_clk);
        tracker.note_op(mode, key, prio);
        @(posedge i_clk);
    endtask

    task automatic sender_gap();
        if (!sender_calm && gaps_on && $urandom_range(0, 2) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    function automatic logic [KB-1:0] pick_key();
        if ($urandom_range(0, 6) == 0)
            return KB'($urandom);
        return key_pool[$urandom_range(0, 7)];
    endfunction

    function automatic logic signed [PB-1:0] pick_prio();
        int t;
        case ($urandom_range(0, 9))
            0: return PB'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: begin
                t = int'($urandom_range(0, 16)) - 8;
                return t[PB-1:0];
            end
        endcase
    endfunction

    function automatic t_mode pick_mode(t_lean lean);
        int unsigned roll;
        int unsigned enq_pct;
        int unsigned deq_pct;
        int unsigned chg_pct;
        roll = $urandom_range(0, 99);
        case (lean)
            LEAN_FILL: begin
                enq_pct = 70; deq_pct = 10; chg_pct = 18;
            end
            LEAN_DRAIN: begin
                enq_pct = 20; deq_pct = 60; chg_pct = 18;
            end
            default: begin
                enq_pct = 40; deq_pct = 30; chg_pct = 27;
            end
        endcase
        if (roll < enq_pct) return MODE_ENQ;
        if (roll < enq_pct + deq_pct) return MODE_DEQ;
        if (roll < enq_pct + deq_pct + chg_pct) return MODE_CHG;
        return MODE_CLR;
    endfunction

    initial begin : stimulus
        t_lean lean;
        lean = LEAN_MIX;
        in_if.valid     <= 1'b0;
        in_if.mode      <= MODE_ENQ;
        in_if.key_value <= '0;
        in_if.prio_in   <= '0;
        i_rst_n         <= 1'b0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 8; i++) key_pool[i] = KB'($urandom);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty cases, extremes, ties, duplicate change, full, clear
        send_word(MODE_DEQ, '0, '0);                    sender_gap();
        send_word(MODE_CHG, 32'd5, -16'sd1);            sender_gap();
        send_word(MODE_ENQ, 32'hffff_ffff, 16'sh7fff);  sender_gap();
        send_word(MODE_ENQ, 32'd0, 16'sh8000);          sender_gap();
        send_word(MODE_ENQ, 32'd5, 16'sd7);             sender_gap();
        send_word(MODE_ENQ, 32'd3, 16'sd7);             sender_gap();
        send_word(MODE_ENQ, 32'd5, 16'sd7);             sender_gap();
        send_word(MODE_CHG, 32'd5, 16'sd7);             sender_gap();
        send_word(MODE_CHG, 32'd5, -16'sd1);            sender_gap();
        send_word(MODE_DEQ, '0, '0);                    sender_gap();
        send_word(MODE_DEQ, '0, '0);                    sender_gap();
        send_word(MODE_ENQ, 32'd3, 16'sd7);             sender_gap();
        for (int i = 0; i < 12; i++) begin
            send_word(MODE_ENQ, KB'($urandom), PB'($urandom));
            sender_gap();
        end
        send_word(MODE_ENQ, 32'h1234_5678, 16'sd0);     sender_gap();
        send_word(MODE_DEQ, '0, '0);                    sender_gap();
        send_word(MODE_CLR, '0, '0);                    sender_gap();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % SEGMENT == 0) begin
                lean    = t_lean'($urandom_range(0, 2));
                gaps_on = $urandom_range(0, 3) != 0;
                key_pool[$urandom_range(2, 7)] = KB'($urandom);
            end
            if (n == HOLD_AT) begin
                sender_calm = 1'b1;
                hold_req    = 1'b1;
            end
            if (n == HOLD_AT + HOLD_BURST) sender_calm = 1'b0;
            if (n == RANDOM_WORDS - CALM_TAIL) begin
                sender_calm = 1'b1;
                sink_calm   = 1'b1;
            end
            send_word(pick_mode(lean), pick_key(), pick_prio());
            sender_gap();
        end
        in_if.valid <= 1'b0;

        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("min_priority_queue_core test passed");
        else
            $display("min_priority_queue_core test failed");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("min_priority_queue_core test failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/mpq_pkg.sv
src/mpq_in_if.sv
src/mpq_out_if.sv
src/mpq_cell.sv
src/mpq_min_tree.sv
src/min_priority_queue_core.sv
dv/mpq_tb_pkg.sv
dv/tb_min_priority_queue_core.sv
